// ===== hw/rtl/wtet_pkg.sv =====
`default_nettype none

package wtet_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WAIT_W  = 31;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ENTRY_W = TAG_W + TIME_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SCHED = 2'd0,
    FUNC_FIRE  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED = 3'd0,
    KIND_DONE  = 3'd1,
    KIND_WAIT  = 3'd2,
    KIND_SCHED = 3'd3,
    KIND_FULL  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_FIRE_SCAN,
    ST_QUERY_SCAN,
    ST_FIRE,
    ST_SHIFT,
    ST_DONE,
    ST_WAIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_SCAN_INIT,
    OP_SCAN_DUE,
    OP_SCAN_ALL,
    OP_FIRE,
    OP_SHIFT,
    OP_DONE,
    OP_WAIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic found;
    logic out_free;
  } status_t;

  // a is not later than b when (b - a) has its sign bit clear
  function automatic logic not_later(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = b - a;
    return ~diff[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wtet_if.sv =====
`default_nettype none

interface wtet_in_if;
  logic                          valid;
  logic                          ready;
  logic [wtet_pkg::FUNC_W-1:0]   func;
  logic [wtet_pkg::TAG_W-1:0]    callback_tag;
  logic [wtet_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, func, callback_tag, time_ms, input ready);
  modport sink   (input valid, func, callback_tag, time_ms, output ready);
endinterface

interface wtet_out_if;
  logic                          valid;
  logic                          ready;
  logic [wtet_pkg::KIND_W-1:0]   kind;
  logic [wtet_pkg::TAG_W-1:0]    fired_tag;
  logic [wtet_pkg::TIME_W-1:0]   fired_time;
  logic [wtet_pkg::WAIT_W-1:0]   wait_ms;
  logic                          pending;
  logic                          last;

  modport source (output valid, kind, fired_tag, fired_time, wait_ms, pending, last,
                  input ready);
  modport sink   (input valid, kind, fired_tag, fired_time, wait_ms, pending, last,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wtet_ram.sv =====
`default_nettype none

module wtet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wtet_ctrl.sv =====
`default_nettype none

module wtet_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [wtet_pkg::FUNC_W-1:0] in_func_i,
  input  wire wtet_pkg::status_t           status_i,
  output      logic                        in_ready_o,
  output      wtet_pkg::cmd_t              cmd_o
);

  wtet_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wtet_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = wtet_pkg::OP_NONE;
    case (state_q)
      wtet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = wtet_pkg::OP_LOAD;
          case (wtet_pkg::func_e'(in_func_i))
            wtet_pkg::FUNC_SCHED: state_d = wtet_pkg::ST_SCHED;
            wtet_pkg::FUNC_FIRE:  state_d = wtet_pkg::ST_FIRE_SCAN;
            wtet_pkg::FUNC_QUERY: state_d = wtet_pkg::ST_QUERY_SCAN;
            default:              state_d = wtet_pkg::ST_IDLE;
          endcase
        end
      end
      wtet_pkg::ST_SCHED: begin
        if (status_i.out_free) begin
          cmd_o.op = wtet_pkg::OP_APPEND;
          state_d  = wtet_pkg::ST_IDLE;
        end
      end
      wtet_pkg::ST_FIRE_SCAN: begin
        cmd_o.op = wtet_pkg::OP_SCAN_DUE;
        if (status_i.scan_done) begin
          state_d = status_i.found ? wtet_pkg::ST_FIRE : wtet_pkg::ST_DONE;
        end
      end
      wtet_pkg::ST_QUERY_SCAN: begin
        cmd_o.op = wtet_pkg::OP_SCAN_ALL;
        if (status_i.scan_done) begin
          state_d = wtet_pkg::ST_WAIT;
        end
      end
      wtet_pkg::ST_FIRE: begin
        if (status_i.out_free) begin
          cmd_o.op = wtet_pkg::OP_FIRE;
          state_d  = wtet_pkg::ST_SHIFT;
        end
      end
      wtet_pkg::ST_SHIFT: begin
        if (status_i.shift_done) begin
          cmd_o.op = wtet_pkg::OP_SCAN_INIT;
          state_d  = wtet_pkg::ST_FIRE_SCAN;
        end else begin
          cmd_o.op = wtet_pkg::OP_SHIFT;
        end
      end
      wtet_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = wtet_pkg::OP_DONE;
          state_d  = wtet_pkg::ST_IDLE;
        end
      end
      wtet_pkg::ST_WAIT: begin
        if (status_i.out_free) begin
          cmd_o.op = wtet_pkg::OP_WAIT;
          state_d  = wtet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wtet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wtet_dp.sv =====
`default_nettype none

module wtet_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wtet_pkg::cmd_t              cmd_i,
  input  wire logic [wtet_pkg::TAG_W-1:0]  in_tag_i,
  input  wire logic [wtet_pkg::TIME_W-1:0] in_time_i,
  output      wtet_pkg::status_t           status_o,
  wtet_out_if.source                       out_o
);

  logic [wtet_pkg::CNT_W-1:0]   count_q, count_d;
  logic [wtet_pkg::CNT_W-1:0]   ptr_q, ptr_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [wtet_pkg::IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [wtet_pkg::IDX_W-1:0]   best_q, best_d;
  logic                         found_q, found_d;
  logic [wtet_pkg::TIME_W-1:0]  cand_time_q, cand_time_d;
  logic [wtet_pkg::TAG_W-1:0]   cand_tag_q, cand_tag_d;
  logic [wtet_pkg::TAG_W-1:0]   tag_q, tag_d;
  logic [wtet_pkg::TIME_W-1:0]  now_q, now_d;

  logic                         out_valid_q;
  logic [wtet_pkg::KIND_W-1:0]  out_kind_q, out_kind_d;
  logic [wtet_pkg::TAG_W-1:0]   out_tag_q, out_tag_d;
  logic [wtet_pkg::TIME_W-1:0]  out_time_q, out_time_d;
  logic [wtet_pkg::WAIT_W-1:0]  out_wait_q, out_wait_d;
  logic                         out_pend_q;
  logic                         out_last_q, out_last_d;
  logic                         emit;

  logic                         ram_we;
  logic [wtet_pkg::IDX_W-1:0]   ram_waddr;
  logic [wtet_pkg::ENTRY_W-1:0] ram_wdata;
  logic [wtet_pkg::ENTRY_W-1:0] ram_rdata;
  logic [wtet_pkg::TAG_W-1:0]   ent_tag;
  logic [wtet_pkg::TIME_W-1:0]  ent_time;
  logic [wtet_pkg::TIME_W-1:0]  wait_diff;
  logic                         rd_more;
  logic                         shift_more;
  logic                         due;
  logic                         out_free;

  wtet_ram #(
    .WIDTH (wtet_pkg::ENTRY_W),
    .DEPTH (wtet_pkg::DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[wtet_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent_tag    = ram_rdata[wtet_pkg::ENTRY_W-1 -: wtet_pkg::TAG_W];
  assign ent_time   = ram_rdata[wtet_pkg::TIME_W-1:0];
  assign wait_diff  = cand_time_q - now_q;
  assign rd_more    = ptr_q < count_q;
  assign shift_more = ptr_q <= count_q;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    count_d     = count_q;
    ptr_d       = ptr_q;
    rd_vld_d    = rd_vld_q;
    rd_idx_d    = rd_idx_q;
    best_d      = best_q;
    found_d     = found_q;
    cand_time_d = cand_time_q;
    cand_tag_d  = cand_tag_q;
    tag_d       = tag_q;
    now_d       = now_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[wtet_pkg::IDX_W-1:0];
    ram_wdata   = {tag_q, now_q};
    emit        = 1'b0;
    out_kind_d  = wtet_pkg::KIND_DONE;
    out_tag_d   = '0;
    out_time_d  = '0;
    out_wait_d  = '0;
    out_last_d  = 1'b1;
    due         = 1'b0;
    case (cmd_i.op)
      wtet_pkg::OP_LOAD: begin
        tag_d    = in_tag_i;
        now_d    = in_time_i;
        ptr_d    = '0;
        rd_vld_d = 1'b0;
        found_d  = 1'b0;
      end
      wtet_pkg::OP_SCAN_INIT: begin
        ptr_d    = '0;
        rd_vld_d = 1'b0;
        found_d  = 1'b0;
      end
      wtet_pkg::OP_SCAN_DUE, wtet_pkg::OP_SCAN_ALL: begin
        rd_vld_d = rd_more;
        rd_idx_d = ptr_q[wtet_pkg::IDX_W-1:0];
        if (rd_more) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (rd_vld_q) begin
          due = (cmd_i.op == wtet_pkg::OP_SCAN_ALL) || wtet_pkg::not_later(ent_time, now_q);
          if (due && (!found_q || wtet_pkg::not_later(ent_time, cand_time_q))) begin
            found_d     = 1'b1;
            best_d      = rd_idx_q;
            cand_time_d = ent_time;
            cand_tag_d  = ent_tag;
          end
        end
      end
      wtet_pkg::OP_APPEND: begin
        emit = 1'b1;
        if (count_q != wtet_pkg::CNT_W'(wtet_pkg::DEPTH)) begin
          ram_we     = 1'b1;
          count_d    = count_q + 1'b1;
          out_kind_d = wtet_pkg::KIND_SCHED;
        end else begin
          out_kind_d = wtet_pkg::KIND_FULL;
        end
      end
      wtet_pkg::OP_FIRE: begin
        emit       = 1'b1;
        out_kind_d = wtet_pkg::KIND_FIRED;
        out_tag_d  = cand_tag_q;
        out_time_d = cand_time_q;
        out_last_d = 1'b0;
        count_d    = count_q - 1'b1;
        ptr_d      = wtet_pkg::CNT_W'(best_q) + 1'b1;
        rd_vld_d   = 1'b0;
      end
      wtet_pkg::OP_SHIFT: begin
        rd_vld_d = shift_more;
        rd_idx_d = ptr_q[wtet_pkg::IDX_W-1:0];
        if (shift_more) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      wtet_pkg::OP_DONE: begin
        emit       = 1'b1;
        out_kind_d = wtet_pkg::KIND_DONE;
      end
      wtet_pkg::OP_WAIT: begin
        emit       = 1'b1;
        out_kind_d = wtet_pkg::KIND_WAIT;
        if (found_q && !wait_diff[wtet_pkg::TIME_W-1]) begin
          out_wait_d = wait_diff[wtet_pkg::WAIT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    cand_time_q <= cand_time_d;
    cand_tag_q  <= cand_tag_d;
    tag_q       <= tag_d;
    now_q       <= now_d;
    if (emit) begin
      out_kind_q <= out_kind_d;
      out_tag_q  <= out_tag_d;
      out_time_q <= out_time_d;
      out_wait_q <= out_wait_d;
      out_pend_q <= count_d != '0;
      out_last_q <= out_last_d;
    end
  end

  assign status_o.scan_done  = !rd_more && !rd_vld_q;
  assign status_o.shift_done = !shift_more && !rd_vld_q;
  assign status_o.found      = found_q;
  assign status_o.out_free   = out_free;

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.fired_tag  = out_tag_q;
  assign out_o.fired_time = out_time_q;
  assign out_o.wait_ms    = out_wait_q;
  assign out_o.pending    = out_pend_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wrap_aware_timer_event_table.sv =====
// Timer event table: up to 32 pending events (tag, 32-bit trigger time) held in arrival order
// in a single-port-read entry RAM, with times compared by signed difference so wraparound is
// harmless. Items are taken one at a time; ready is high only between items. A schedule
// appends the entry, or reports a full table, and emits one result; a query scans all stored
// entries and emits the wait to the earliest one; a fire scans for due entries, emits the
// earliest, compacts the table behind it to keep arrival order and scans again, then emits
// the done result. The scans and the compaction read the entry RAM one entry per cycle, and
// each result waits while the result channel stalls. Results pass through an output
// register, so one finished result may wait while the next item is accepted.
`default_nettype none

module wrap_aware_timer_event_table (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wtet_in_if.sink    in_i,
  wtet_out_if.source out_o
);

  wtet_pkg::cmd_t    cmd;
  wtet_pkg::status_t status;

  wtet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  wtet_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_tag_i  (in_i.callback_tag),
    .in_time_i (in_i.time_ms),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/wtet_checker.sv =====
`default_nettype none

module wtet_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [wtet_pkg::FUNC_W-1:0] in_func_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [wtet_pkg::KIND_W-1:0] out_kind_i,
  input wire logic [wtet_pkg::TAG_W-1:0]  out_tag_i,
  input wire logic [wtet_pkg::TIME_W-1:0] out_time_i,
  input wire logic                        out_last_i
);

  // a stalled result transaction keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_kind_i) && $stable(out_last_i)
      && $stable(out_tag_i) && $stable(out_time_i))
    else $error("result payload changed while stalled");

  // only fired events leave the item open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_kind_i == wtet_pkg::KIND_FIRED) == !out_last_i))
    else $error("last flag does not match result kind");

  // a valid item keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i
      && (in_func_i == wtet_pkg::FUNC_SCHED || in_func_i == wtet_pkg::FUNC_FIRE
          || in_func_i == wtet_pkg::FUNC_QUERY) |=> !in_ready_i)
    else $error("new transaction accepted while an item is in progress");

  // event fields are zero on every other kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != wtet_pkg::KIND_FIRED |-> out_tag_i == '0 && out_time_i == '0)
    else $error("event fields set on a non-event result");

endmodule

bind wrap_aware_timer_event_table wtet_checker u_wtet_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_tag_i   (out_o.fired_tag),
  .out_time_i  (out_o.fired_time),
  .out_last_i  (out_o.last)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import wtet_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 150;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    kind_e             kind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] fire_ms;
    logic [WAIT_W-1:0] wait_ms;
    logic              pending;
    logic              last;
  } timer_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] tm;
    bit                typed;
    timer_result_t     res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wtet_in_if  in_if ();
  wtet_out_if out_if ();

  wrap_aware_timer_event_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // table mirror
  logic [TAG_W-1:0]  slot_tags  [DEPTH];
  logic [TIME_W-1:0] slot_times [DEPTH];
  int                slot_count = 0;

  timer_result_t timer_answers [$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            hold_req    = 1'b0;
  stim_row_t     directed_rows [$];

  // a is not later than b when (b - a) is non-negative
  function automatic bit no_later(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = b - a;
    return d[TIME_W-1] == 1'b0;
  endfunction

  function automatic int earliest_slot(logic [TIME_W-1:0] now, bit due_only);
    int best;
    int i;
    best = -1;
    for (i = 0; i < slot_count; i++) begin
      if (due_only && !no_later(slot_times[i], now))
        continue;
      if (best < 0 || no_later(slot_times[i], slot_times[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void push_answer(kind_e kind, logic [TAG_W-1:0] tag,
                                      logic [TIME_W-1:0] tm, logic [WAIT_W-1:0] w,
                                      logic last);
    timer_result_t r;
    r.kind    = kind;
    r.tag     = tag;
    r.fire_ms = tm;
    r.wait_ms = w;
    r.pending = (slot_count != 0);
    r.last    = last;
    timer_answers = {timer_answers, r};
  endfunction

  function automatic void add_row(stim_row_t s);
    directed_rows = {directed_rows, s};
  endfunction

  function automatic void apply_timer_item(logic [FUNC_W-1:0] f, logic [TAG_W-1:0] tag,
                                           logic [TIME_W-1:0] now);
    int                b;
    int                i;
    logic [TAG_W-1:0]  ft;
    logic [TIME_W-1:0] fm;
    logic [TIME_W-1:0] d;
    logic [WAIT_W-1:0] w;
    case (f)
      FUNC_SCHED: begin
        if (slot_count < DEPTH) begin
          slot_tags[slot_count]  = tag;
          slot_times[slot_count] = now;
          slot_count++;
          push_answer(KIND_SCHED, '0, '0, '0, 1'b1);
        end else begin
          push_answer(KIND_FULL, '0, '0, '0, 1'b1);
        end
      end
      FUNC_FIRE: begin
        b = earliest_slot(now, 1'b1);
        while (b >= 0) begin
          ft = slot_tags[b];
          fm = slot_times[b];
          for (i = b; i + 1 < slot_count; i++) begin
            slot_tags[i]  = slot_tags[i + 1];
            slot_times[i] = slot_times[i + 1];
          end
          slot_count--;
          push_answer(KIND_FIRED, ft, fm, '0, 1'b0);
          b = earliest_slot(now, 1'b1);
        end
        push_answer(KIND_DONE, '0, '0, '0, 1'b1);
      end
      FUNC_QUERY: begin
        w = '0;
        b = earliest_slot(now, 1'b0);
        if (b >= 0 && no_later(now, slot_times[b])) begin
          // sign bit clear, so the difference already fits the wait field
          d = slot_times[b] - now;
          w = d[WAIT_W-1:0];
        end
        push_answer(KIND_WAIT, '0, '0, w, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t plain(logic [FUNC_W-1:0] f, logic [TAG_W-1:0] tag,
                                      logic [TIME_W-1:0] tm);
    stim_row_t s;
    s       = '0;
    s.func  = f;
    s.tag   = tag;
    s.tm    = tm;
    return s;
  endfunction

  function automatic stim_row_t typed(logic [FUNC_W-1:0] f, logic [TAG_W-1:0] tag,
                                      logic [TIME_W-1:0] tm, kind_e kind,
                                      logic [WAIT_W-1:0] w, logic pend);
    stim_row_t s;
    s             = plain(f, tag, tm);
    s.typed       = 1'b1;
    s.res.kind    = kind;
    s.res.wait_ms = w;
    s.res.pending = pend;
    s.res.last    = 1'b1;
    return s;
  endfunction

  function automatic string show(timer_result_t r);
    return $sformatf("kind %0d tag %h time %h wait %h pend %b last %b",
                     r.kind, r.tag, r.fire_ms, r.wait_ms, r.pending, r.last);
  endfunction

  task automatic offer_item(input logic [FUNC_W-1:0] f, input logic [TAG_W-1:0] tag,
                            input logic [TIME_W-1:0] tm, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.callback_tag <= tag;
    in_if.time_ms      <= tm;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    apply_timer_item(f, tag, tm);
  endtask

  always @(posedge clk_i) begin : result_check
    timer_result_t got;
    timer_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind    = kind_e'(out_if.kind);
      got.tag     = out_if.fired_tag;
      got.fire_ms = out_if.fired_time;
      got.wait_ms = out_if.wait_ms;
      got.pending = out_if.pending;
      got.last    = out_if.last;
      if (timer_answers.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected transaction: %s", show(got));
      end else begin
        want = timer_answers.pop_front();
        if (got.kind !== want.kind || got.tag !== want.tag || got.fire_ms !== want.fire_ms ||
            got.wait_ms !== want.wait_ms || got.pending !== want.pending ||
            got.last !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, runs of steady ready, one long hold-off on request
  initial begin : result_drive
    int stall;
    int run;
    stall = 0;
    run   = 0;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (run > 0)
          run--;
        else if ($urandom_range(0, 19) == 0)
          run = $urandom_range(20, 80);
        else
          stall = pick_gap();
      end
    end
  end

  initial begin : item_drive
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] tm;
    logic [TIME_W-1:0] last_sched_ms;
    int                random_items;
    int                phase;
    int                burst;
    bit                calm;

    in_if.valid        = 1'b0;
    in_if.func         = '0;
    in_if.callback_tag = '0;
    in_if.time_ms      = '0;

    add_row(typed(FUNC_QUERY, 16'h0000, 32'h0000_0000, KIND_WAIT, '0, 1'b0));
    add_row(typed(FUNC_FIRE, 16'hFFFF, 32'hFFFF_FFFF, KIND_DONE, '0, 1'b0));
    add_row(plain(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF));
    add_row(typed(FUNC_SCHED, 16'h0000, 32'h0000_0000, KIND_SCHED, '0, 1'b1));
    add_row(typed(FUNC_SCHED, 16'hFFFF, 32'hFFFF_FFFF, KIND_SCHED, '0, 1'b1));
    add_row(typed(FUNC_SCHED, 16'h1234, 32'h7FFF_FFFF, KIND_SCHED, '0, 1'b1));
    add_row(typed(FUNC_SCHED, 16'h00AA, 32'h8000_0000, KIND_SCHED, '0, 1'b1));
    add_row(plain(FUNC_QUERY, 16'h0000, 32'h0000_0000));
    add_row(plain(FUNC_QUERY, 16'h5A5A, 32'h8000_0001));
    // wraps: the event at all-ones is earlier than the one at zero
    add_row(plain(FUNC_FIRE, 16'h0000, 32'h0000_0010));
    add_row(typed(FUNC_QUERY, 16'h0000, 32'h0000_0000, KIND_WAIT, 31'h7FFF_FFFF, 1'b1));
    add_row(typed(FUNC_SCHED, 16'h0101, 32'd100, KIND_SCHED, '0, 1'b1));
    add_row(typed(FUNC_SCHED, 16'h0202, 32'd100, KIND_SCHED, '0, 1'b1));
    add_row(typed(FUNC_SCHED, 16'hAAAA, 32'd50, KIND_SCHED, '0, 1'b1));
    // equal times: the later arrival goes first
    add_row(plain(FUNC_FIRE, 16'h5555, 32'd100));
    add_row(plain(FUNC_FIRE, 16'h0000, 32'hFFFF_FFFF));
    add_row(plain(FUNC_QUERY, 16'h0000, 32'h7FFF_FFFF));
    add_row(plain(FUNC_FIRE, 16'h0000, 32'h7FFF_FFFF));
    add_row(typed(FUNC_QUERY, 16'hFFFF, 32'h1234_5678, KIND_WAIT, '0, 1'b0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].func, directed_rows[i].tag, directed_rows[i].tm, pick_gap());
      if (directed_rows[i].typed)
        timer_answers[timer_answers.size() - 1] = directed_rows[i].res;
    end

    // random part starts just short of the wrap
    now_ms        = 32'hFFFF_FF00 - $urandom_range(0, 400);
    last_sched_ms = now_ms;
    random_items  = 0;
    phase         = 0;
    while (random_items < RANDOM_ITEMS) begin
      calm = (phase % 5 == 2);
      if (phase == 0) begin
        hold_req = 1'b1;
        burst    = DEPTH + 4;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(DEPTH - 4, DEPTH + 3);
      end else begin
        burst = $urandom_range(1, 8);
      end
      repeat (burst) begin
        case ($urandom_range(0, 19))
          0:       tm = $urandom;
          1:       tm = last_sched_ms;
          2:       tm = now_ms - $urandom_range(0, 200);
          default: tm = now_ms + $urandom_range(0, 600);
        endcase
        last_sched_ms = tm;
        offer_item(FUNC_SCHED, TAG_W'($urandom_range(0, 65535)), tm, calm ? 0 : pick_gap());
        random_items++;
        if ($urandom_range(0, 5) == 0) begin
          offer_item(FUNC_QUERY, TAG_W'($urandom_range(0, 65535)),
                     ($urandom_range(0, 9) == 0) ? $urandom : now_ms, calm ? 0 : pick_gap());
          random_items++;
        end
      end
      if ($urandom_range(0, 9) == 0)
        offer_item(FUNC_UNUSED, TAG_W'($urandom_range(0, 65535)), $urandom, pick_gap());
      if ($urandom_range(0, 14) == 0)
        now_ms = now_ms + 32'h2000_0000 + $urandom_range(0, 65535);
      else
        now_ms = now_ms + $urandom_range(0, 400);
      offer_item(FUNC_FIRE, TAG_W'($urandom_range(0, 65535)),
                 ($urandom_range(0, 9) == 0) ? $urandom : now_ms, calm ? 0 : pick_gap());
      random_items++;
      if ($urandom_range(0, 2) == 0) begin
        offer_item(FUNC_QUERY, TAG_W'($urandom_range(0, 65535)), now_ms,
                   calm ? 0 : pick_gap());
        random_items++;
      end
      phase++;
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (timer_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && timer_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
